// ===== rtl/sol_pkg.sv =====
// Shared widths and request codes for the segment offset lookup block.
`timescale 1ns / 1ps

package sol_pkg;

  localparam int FUNC_W   = 2;
  localparam int LEN_W    = 32;
  localparam int OFFS_W   = 48;
  localparam int SEGNUM_W = 11;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

endpackage

// ===== rtl/sol_req_if.sv =====
// Request channel: one table operation with its operands.
`timescale 1ns / 1ps

interface sol_req_if;
  logic                        valid;
  logic                        ready;
  logic [sol_pkg::FUNC_W-1:0]  func;
  logic [sol_pkg::LEN_W-1:0]   segment_length;
  logic [sol_pkg::OFFS_W-1:0]  stream_offset;

  modport source (output valid, func, segment_length, stream_offset, input ready);
  modport sink   (input valid, func, segment_length, stream_offset, output ready);
endinterface

// ===== rtl/sol_rsp_if.sv =====
// Response channel: the outcome of one table operation.
`timescale 1ns / 1ps

interface sol_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [sol_pkg::SEGNUM_W-1:0] segment_number;
  logic [sol_pkg::LEN_W-1:0]    offset_in_segment;
  logic [sol_pkg::SEGNUM_W-1:0] segment_count;
  logic [sol_pkg::OFFS_W-1:0]   total_length;

  modport source (output valid, hit, segment_number, offset_in_segment, segment_count,
                  total_length, input ready);
  modport sink   (input valid, hit, segment_number, offset_in_segment, segment_count,
                  total_length, output ready);
endinterface

// ===== rtl/segment_offset_lookup.sv =====
// Segment end offset table with append, clear and binary search lookup.
//
//   Channel  Direction  Carries
//   req      in         func, segment_length, stream_offset
//   rsp      out        hit, segment_number, offset_in_segment, segment_count, total_length
//
// Append, clear and the unused code go from acceptance through S_DONE to the response register.
// A lookup searches the table in steps: each search step
// is one read of the table's single read port and one compare of the registered data.
// Reset clears the count, the sum and the handshake state; the table itself is not cleared.
// Only one request is in work at a time; a finished response waits in the output
// register while the next request is accepted.
`timescale 1ns / 1ps

module segment_offset_lookup #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  sol_req_if.sink    req,
  sol_rsp_if.source  rsp
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_PREV,
    S_DONE
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            entry_count;
  logic [sol_pkg::OFFS_W-1:0]  running_sum;
  logic [sol_pkg::OFFS_W-1:0]  query;
  logic [IDX_W-1:0]            lo;
  logic [IDX_W-1:0]            hi;
  logic [IDX_W-1:0]            mid;
  logic                        res_hit;
  logic [CNT_W-1:0]            res_segnum;
  logic [sol_pkg::LEN_W-1:0]   res_inseg;

  logic [sol_pkg::OFFS_W-1:0]  end_offsets [MAX_SEGMENTS];
  logic [sol_pkg::OFFS_W-1:0]  rd_data;
  logic [IDX_W-1:0]            rd_idx;
  logic                        wr_en;
  logic [sol_pkg::OFFS_W-1:0]  sum_next;
  logic [IDX_W-1:0]            mid_next;
  logic                        accept;
  logic                        not_full;
  logic                        out_free;
  logic [31:0]                 count_ext;
  logic [31:0]                 segnum_ext;
  logic [sol_pkg::OFFS_W-1:0]  inseg_full;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign not_full  = entry_count < CNT_W'(MAX_SEGMENTS);
  assign sum_next  = running_sum + sol_pkg::OFFS_W'(req.segment_length);
  assign mid_next  = lo + ((hi - lo) >> 1);
  assign wr_en     = accept && (req.func == sol_pkg::FUNC_APPEND) && not_full;
  assign out_free  = !rsp.valid || rsp.ready;
  assign inseg_full = query - rd_data;
  assign rd_idx    = (state == S_SEARCH && lo < hi) ? mid_next : (lo - 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      end_offsets[entry_count[IDX_W-1:0]] <= sum_next;
    end
    rd_data <= end_offsets[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      running_sum <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            query      <= req.stream_offset;
            res_hit    <= 1'b0;
            res_segnum <= '0;
            res_inseg  <= '0;
            state      <= S_DONE;
            case (req.func)
              sol_pkg::FUNC_APPEND: begin
                if (not_full) begin
                  running_sum <= sum_next;
                  entry_count <= entry_count + 1'b1;
                  res_hit     <= 1'b1;
                end
              end
              sol_pkg::FUNC_CLEAR: begin
                entry_count <= '0;
                running_sum <= '0;
              end
              sol_pkg::FUNC_LOOKUP: begin
                if (entry_count != '0 && req.stream_offset < running_sum) begin
                  lo    <= '0;
                  hi    <= IDX_W'(entry_count - 1'b1);
                  state <= S_SEARCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= S_CMP;
          end else begin
            res_hit    <= 1'b1;
            res_segnum <= CNT_W'(lo) + 1'b1;
            if (lo == '0) begin
              res_inseg <= query[sol_pkg::LEN_W-1:0];
              state     <= S_DONE;
            end else begin
              state <= S_PREV;
            end
          end
        end
        S_CMP: begin
          if (rd_data > query) begin
            hi <= mid;
          end else begin
            lo <= mid + 1'b1;
          end
          state <= S_SEARCH;
        end
        S_PREV: begin
          res_inseg <= inseg_full[sol_pkg::LEN_W-1:0];
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid             <= 1'b1;
            rsp.hit               <= res_hit;
            rsp.segment_number    <= segnum_ext[sol_pkg::SEGNUM_W-1:0];
            rsp.offset_in_segment <= res_inseg;
            rsp.segment_count     <= count_ext[sol_pkg::SEGNUM_W-1:0];
            rsp.total_length      <= running_sum;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign count_ext  = 32'(entry_count);
  assign segnum_ext = 32'(res_segnum);

endmodule

// ===== rtl/sol_check.sv =====
// Port-level assertions for the segment offset lookup block, with their bind.
`timescale 1ns / 1ps

module sol_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_hit,
  input logic [sol_pkg::SEGNUM_W-1:0] rsp_segment_number,
  input logic [sol_pkg::LEN_W-1:0]    rsp_offset_in_segment,
  input logic [sol_pkg::SEGNUM_W-1:0] rsp_segment_count
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while the previous one was still in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_segment_number)
                                   && $stable(rsp_offset_in_segment)))
    else $error("stalled response changed");

  a_segnum_in_table: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_segment_number != '0) |->
      (rsp_hit && rsp_segment_number <= rsp_segment_count))
    else $error("reported segment lies outside the table");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_hit) |->
      (rsp_segment_number == '0 && rsp_offset_in_segment == '0))
    else $error("miss response carries a segment or offset");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind segment_offset_lookup sol_check u_sol_check (
  .clk                   (clk),
  .rst                   (rst),
  .req_valid             (req.valid),
  .req_ready             (req.ready),
  .rsp_valid             (rsp.valid),
  .rsp_ready             (rsp.ready),
  .rsp_hit               (rsp.hit),
  .rsp_segment_number    (rsp.segment_number),
  .rsp_offset_in_segment (rsp.offset_in_segment),
  .rsp_segment_count     (rsp.segment_count)
);

// ===== verif/tb_top.sv =====
// Testbench for segment_offset_lookup: directed table, a fill past capacity, then random sessions, checked per field.
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_DEPTH = 1024;
  localparam int ITEM_TARGET = 1850;
  localparam logic [sol_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [sol_pkg::FUNC_W-1:0] func;
    logic [sol_pkg::LEN_W-1:0]  seg_len;
    logic [sol_pkg::OFFS_W-1:0] offs;
  } req_t;

  typedef struct packed {
    logic                         hit;
    logic [sol_pkg::SEGNUM_W-1:0] seg_num;
    logic [sol_pkg::LEN_W-1:0]    in_seg;
    logic [sol_pkg::SEGNUM_W-1:0] seg_cnt;
    logic [sol_pkg::OFFS_W-1:0]   total;
  } outcome_t;

  typedef struct {
    req_t     op;
    bit       typed;
    outcome_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst;

  sol_req_if req_ch();
  sol_rsp_if rsp_ch();

  segment_offset_lookup #(.MAX_SEGMENTS(TABLE_DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #4 clk = ~clk;

  logic [sol_pkg::OFFS_W-1:0] end_mark [TABLE_DEPTH];
  int unsigned                entry_total = 0;
  logic [sol_pkg::OFFS_W-1:0] byte_total = '0;

  outcome_t pending_outcomes[$];
  step_t    plan[$];

  int n_errors = 0;
  int n_sent = 0;
  int n_rcvd = 0;
  int n_appends = 0;
  int n_dropped = 0;
  int n_lookups = 0;
  int n_lookup_hits = 0;
  int n_clears = 0;
  int n_unused = 0;
  int deepest = 0;

  function automatic outcome_t predict_outcome(input req_t r);
    outcome_t o;
    int unsigned i;
    logic [sol_pkg::OFFS_W-1:0] start;
    o = '0;
    case (r.func)
      sol_pkg::FUNC_APPEND: begin
        if (entry_total < TABLE_DEPTH) begin
          byte_total = byte_total + sol_pkg::OFFS_W'(r.seg_len);
          end_mark[entry_total] = byte_total;
          entry_total++;
          o.hit = 1'b1;
        end
      end
      sol_pkg::FUNC_CLEAR: begin
        entry_total = 0;
        byte_total = '0;
      end
      sol_pkg::FUNC_LOOKUP: begin
        if (r.offs < byte_total) begin
          i = 0;
          while (end_mark[i] <= r.offs) i++;
          start = (i == 0) ? '0 : end_mark[i - 1];
          o.hit = 1'b1;
          o.seg_num = sol_pkg::SEGNUM_W'(i + 1);
          o.in_seg = sol_pkg::LEN_W'(r.offs - start);
        end
      end
      default: ;
    endcase
    o.seg_cnt = sol_pkg::SEGNUM_W'(entry_total);
    o.total = byte_total;
    return o;
  endfunction

  function automatic logic [sol_pkg::LEN_W-1:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return '0;
    if (sel < 50) return $urandom_range(1, 16);
    if (sel < 75) return $urandom_range(17, 65535);
    return $urandom;
  endfunction

  function automatic logic [sol_pkg::OFFS_W-1:0] pick_offset();
    int unsigned sel;
    int unsigned e;
    logic [sol_pkg::OFFS_W-1:0] wide;
    sel = $urandom_range(0, 99);
    wide = {16'($urandom), 32'($urandom)};
    if (entry_total == 0 || byte_total == 0) return (sel < 50) ? '0 : wide;
    if (sel < 8) return wide;
    if (sel < 55) return wide % byte_total;
    e = $urandom_range(0, entry_total - 1);
    if (sel < 75) return end_mark[e];
    if (sel < 90) return end_mark[e] - sol_pkg::OFFS_W'(end_mark[e] != 0);
    if (sel < 95) return byte_total;
    return byte_total - 1;
  endfunction

  function automatic void add_step(input logic [sol_pkg::FUNC_W-1:0] f,
                                   input logic [sol_pkg::LEN_W-1:0] len,
                                   input logic [sol_pkg::OFFS_W-1:0] offs,
                                   input bit typed = 1'b0,
                                   input logic h = 1'b0,
                                   input logic [sol_pkg::SEGNUM_W-1:0] num = '0,
                                   input logic [sol_pkg::LEN_W-1:0] in_seg = '0,
                                   input logic [sol_pkg::SEGNUM_W-1:0] cnt = '0,
                                   input logic [sol_pkg::OFFS_W-1:0] total = '0);
    step_t s;
    s.op = '{f, len, offs};
    s.typed = typed;
    s.want = '{h, num, in_seg, cnt, total};
    plan = {plan, s};
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < 50)
      $display("Mismatch on %s at response %0d: got %0h, expected %0h", field, n_rcvd, got, want);
    n_errors++;
  endtask

  task automatic send_request(input req_t r, input bit typed = 1'b0,
                              input outcome_t want = '0);
    outcome_t p;
    int idle;
    idle = (n_sent >= 300 && n_sent < 650) ? 0 : 12;
    while ($urandom_range(0, 99) < idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= r.func;
    req_ch.segment_length <= r.seg_len;
    req_ch.stream_offset <= r.offs;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = predict_outcome(r);
    pending_outcomes = {pending_outcomes, (typed ? want : p)};
    n_sent++;
    case (r.func)
      sol_pkg::FUNC_APPEND: begin
        n_appends++;
        if (!p.hit) n_dropped++;
      end
      sol_pkg::FUNC_CLEAR:  n_clears++;
      sol_pkg::FUNC_LOOKUP: begin
        n_lookups++;
        if (p.hit) n_lookup_hits++;
      end
      default:     n_unused++;
    endcase
    if (entry_total > deepest) deepest = entry_total;
  endtask

  initial begin : response_side
    int hold_left;
    outcome_t want;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unexpected response", 64'd0, 64'd0);
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_ch.hit !== want.hit)
            report_mismatch("hit", 64'(rsp_ch.hit), 64'(want.hit));
          if (rsp_ch.segment_number !== want.seg_num)
            report_mismatch("segment_number", 64'(rsp_ch.segment_number), 64'(want.seg_num));
          if (rsp_ch.offset_in_segment !== want.in_seg)
            report_mismatch("offset_in_segment", 64'(rsp_ch.offset_in_segment),
                            64'(want.in_seg));
          if (rsp_ch.segment_count !== want.seg_cnt)
            report_mismatch("segment_count", 64'(rsp_ch.segment_count), 64'(want.seg_cnt));
          if (rsp_ch.total_length !== want.total)
            report_mismatch("total_length", 64'(rsp_ch.total_length), 64'(want.total));
        end
        n_rcvd++;
        if (n_rcvd == 400) hold_left = 300;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (n_rcvd >= 700 && n_rcvd < 1000) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  initial begin : request_side
    int n_fill;
    int n_items;
    int unsigned sel;
    n_fill = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func <= sol_pkg::FUNC_CLEAR;
    req_ch.segment_length <= '0;
    req_ch.stream_offset <= '0;

    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'd0, 1'b1, 1'b0, 11'd0, 32'd0, 11'd0, 48'd0);
    add_step(FUNC_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 11'd0, 32'd0, 11'd0,
             48'd0);
    add_step(sol_pkg::FUNC_CLEAR, 32'd0, 48'd0, 1'b1, 1'b0, 11'd0, 32'd0, 11'd0, 48'd0);
    add_step(sol_pkg::FUNC_APPEND, 32'hFFFF_FFFF, 48'd0, 1'b1, 1'b1, 11'd0, 32'd0, 11'd1,
             48'hFFFF_FFFF);
    add_step(sol_pkg::FUNC_APPEND, 32'd0, 48'd0, 1'b1, 1'b1, 11'd0, 32'd0, 11'd2,
             48'hFFFF_FFFF);
    add_step(sol_pkg::FUNC_APPEND, 32'd1, 48'd0, 1'b1, 1'b1, 11'd0, 32'd0, 11'd3,
             48'h1_0000_0000);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'd0, 1'b1, 1'b1, 11'd1, 32'd0, 11'd3,
             48'h1_0000_0000);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'hFFFF_FFFE, 1'b1, 1'b1, 11'd1, 32'hFFFF_FFFE,
             11'd3, 48'h1_0000_0000);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'hFFFF_FFFF, 1'b1, 1'b1, 11'd3, 32'd0, 11'd3,
             48'h1_0000_0000);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'h1_0000_0000, 1'b1, 1'b0, 11'd0, 32'd0, 11'd3,
             48'h1_0000_0000);
    add_step(sol_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 11'd0,
             32'd0, 11'd3, 48'h1_0000_0000);
    add_step(FUNC_UNUSED, 32'd5, 48'd7, 1'b1, 1'b0, 11'd0, 32'd0, 11'd3, 48'h1_0000_0000);
    add_step(sol_pkg::FUNC_APPEND, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'h1_7FFF_FFFF);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'h1_0000_0000);
    add_step(sol_pkg::FUNC_CLEAR, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 11'd0, 32'd0,
             11'd0, 48'd0);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'd0, 1'b1, 1'b0, 11'd0, 32'd0, 11'd0, 48'd0);
    add_step(sol_pkg::FUNC_APPEND, 32'd0, 48'd0, 1'b1, 1'b1, 11'd0, 32'd0, 11'd1, 48'd0);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'd0, 1'b1, 1'b0, 11'd0, 32'd0, 11'd1, 48'd0);
    add_step(sol_pkg::FUNC_APPEND, 32'd5, 48'd0);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'd4);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'd5);
    add_step(sol_pkg::FUNC_APPEND, 32'hAAAA_5555, 48'h5555_AAAA_5555);
    add_step(sol_pkg::FUNC_LOOKUP, 32'd0, 48'd5);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_request(plan[i].op, plan[i].typed, plan[i].want);

    // Fill the table past capacity so the last appends are dropped, then search the full table.
    send_request('{sol_pkg::FUNC_CLEAR, pick_length(), pick_offset()});
    while (n_fill < TABLE_DEPTH + 6) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        send_request('{FUNC_UNUSED, pick_length(), pick_offset()});
      end else if (sel < 11) begin
        send_request('{sol_pkg::FUNC_LOOKUP, pick_length(), pick_offset()});
      end else begin
        send_request('{sol_pkg::FUNC_APPEND, pick_length(), pick_offset()});
        n_fill++;
      end
    end
    repeat (60) send_request('{sol_pkg::FUNC_LOOKUP, pick_length(), pick_offset()});

    while (n_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8)
        send_request('{sol_pkg::FUNC_CLEAR, pick_length(), pick_offset()});
      n_items = $urandom_range(2, 40);
      repeat (n_items) begin
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
          send_request('{FUNC_UNUSED, pick_length(), pick_offset()});
        end else if (sel < 7) begin
          send_request('{sol_pkg::FUNC_CLEAR, pick_length(), pick_offset()});
        end else if (sel < 50) begin
          send_request('{sol_pkg::FUNC_APPEND, pick_length(), pick_offset()});
        end else begin
          send_request('{sol_pkg::FUNC_LOOKUP, pick_length(), pick_offset()});
        end
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests: %0d appends (%0d dropped at capacity), %0d lookups (%0d hits),",
             n_sent, n_appends, n_dropped, n_lookups, n_lookup_hits);
    $display("%0d clears, %0d unused codes; deepest table %0d segments, %0d mismatches.",
             n_clears, n_unused, deepest, n_errors);
    if (n_errors == 0 && pending_outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Timeout with %0d responses still outstanding.", pending_outcomes.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sol_pkg.sv
rtl/sol_req_if.sv
rtl/sol_rsp_if.sv
rtl/segment_offset_lookup.sv
rtl/sol_check.sv
verif/tb_top.sv
